// ===== hw/rtl/balanced_dual_shift_queue_macros.svh =====
// Assertion macros shared by the queue checker.
`ifndef BALANCED_DUAL_SHIFT_QUEUE_MACROS_SVH
`define BALANCED_DUAL_SHIFT_QUEUE_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define BDSQ_ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bdsq assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define BDSQ_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bdsq assertion failed");

`endif

// ===== hw/rtl/bdsq_pkg.sv =====
// Shared types and constants for the balanced dual shift queue.
`timescale 1ns / 1ps
package bdsq_pkg;

  // Default number of slots in each queue
  localparam int unsigned QUEUE_DEPTH_DEF = 16;

  // Marker byte held by empty slots ('-')
  localparam logic [7:0] EMPTY_MARK = 8'd45;

  // Width of the count ports
  localparam int unsigned COUNT_W = 5;

  // Item opcodes
  typedef enum logic [2:0] {
    OP_PUSH_DROP = 3'd0,
    OP_PUSH_OVR  = 3'd1,
    OP_POP       = 3'd2,
    OP_BAL_PUSH  = 3'd3,
    OP_BAL_POP   = 3'd4
  } opcode_e;

  // Command from the top level to one queue lane
  typedef enum logic [1:0] {
    LANE_IDLE     = 2'd0,
    LANE_PUSH     = 2'd1,
    LANE_PUSH_OVR = 2'd2,
    LANE_POP      = 2'd3
  } lane_cmd_e;

  // Per-lane status back to the top level
  typedef struct packed {
    logic [7:0] head_q;  // head before the step
    logic [7:0] head_d;  // head after the step
    logic [7:0] tail_d;  // tail after the step
    logic       popped;  // an entry was removed
    logic       dropped; // a non-overwriting push found the lane full
  } lane_stat_t;

endpackage

// ===== hw/rtl/balanced_dual_shift_queue.sv =====
// Top level of the balanced dual shift queue.
//
// Two byte queues, A and B, each QUEUE_DEPTH slots, built as rows of shift
// cells with the head always in the first cell. An item (opcode_i,
// queue_select_i, data_in_i) is taken at a rising edge where start_i is high
// and busy_o is low; busy_o stays low, so an item may be issued every cycle.
// Each item yields one result on the next cycle, flagged by result_valid_o
// for exactly one cycle; throughput is 1 item per cycle. All cells
// of a queue move one slot toward the head in the same cycle on a pop
// or on an overwriting push to a full queue, which evicts the head.
// Balanced pushes go to the shorter queue (A on a tie), balanced pops to the
// longer one (A on a tie). count_a_o/count_b_o report fill modulo 32.
// Reset (rst_ni low, asynchronous) empties both queues, fills every slot
// with '-' and clears the result strobe. The receiver cannot stall: a result
// is shown for one cycle only and must be captured then.
`timescale 1ns / 1ps
module balanced_dual_shift_queue #(
  parameter int unsigned QUEUE_DEPTH = bdsq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic [2:0] opcode_i,
  input  logic       queue_select_i,
  input  logic [7:0] data_in_i,
  output logic       result_valid_o,
  output logic [7:0] data_out_o,
  output logic       pop_valid_o,
  output logic       push_dropped_o,
  output logic [4:0] count_a_o,
  output logic [4:0] count_b_o,
  output logic [7:0] front_selected_o,
  output logic [7:0] back_selected_o
);
  import bdsq_pkg::*;

  localparam int unsigned FW = $clog2(QUEUE_DEPTH + 1);

  logic          accept;
  logic          sel;
  lane_cmd_e     cmd, cmd_a, cmd_b;
  logic [FW-1:0] fill_a_q, fill_a_d, fill_b_q, fill_b_d, fill_sel_d;
  lane_stat_t    stat_a, stat_b, stat_sel;

  logic         valid_q;
  logic [7:0]   data_out_q, data_out_d;
  logic         pop_valid_q, push_dropped_q;
  logic [COUNT_W-1:0] count_a_q, count_b_q;
  logic [7:0]   front_q, front_d, back_q, back_d;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // Queue choice and lane command
  always_comb begin
    sel = queue_select_i;
    cmd = LANE_IDLE;
    unique case (opcode_i)
      OP_PUSH_DROP: cmd = LANE_PUSH;
      OP_PUSH_OVR:  cmd = LANE_PUSH_OVR;
      OP_POP:       cmd = LANE_POP;
      OP_BAL_PUSH: begin
        cmd = LANE_PUSH;
        sel = (fill_a_q <= fill_b_q) ? 1'b0 : 1'b1;
      end
      OP_BAL_POP: begin
        cmd = LANE_POP;
        sel = (fill_a_q >= fill_b_q) ? 1'b0 : 1'b1;
      end
      default: cmd = LANE_IDLE;
    endcase
    if (!accept) begin
      cmd = LANE_IDLE;
    end
    cmd_a = sel ? LANE_IDLE : cmd;
    cmd_b = sel ? cmd : LANE_IDLE;
  end

  bdsq_lane #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_lane_a (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd_a),
    .data_i   (data_in_i),
    .fill_q_o (fill_a_q),
    .fill_d_o (fill_a_d),
    .stat_o   (stat_a)
  );

  bdsq_lane #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_lane_b (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd_b),
    .data_i   (data_in_i),
    .fill_q_o (fill_b_q),
    .fill_d_o (fill_b_d),
    .stat_o   (stat_b)
  );

  // Result fields from the selected lane
  assign stat_sel   = sel ? stat_b : stat_a;
  assign fill_sel_d = sel ? fill_b_d : fill_a_d;
  assign data_out_d = stat_sel.popped ? stat_sel.head_q : EMPTY_MARK;
  assign front_d    = (fill_sel_d == '0) ? EMPTY_MARK : stat_sel.head_d;
  assign back_d     = (fill_sel_d == '0) ? EMPTY_MARK : stat_sel.tail_d;

  // Result register, loaded once per item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q        <= 1'b0;
      data_out_q     <= EMPTY_MARK;
      pop_valid_q    <= 1'b0;
      push_dropped_q <= 1'b0;
      count_a_q      <= '0;
      count_b_q      <= '0;
      front_q        <= EMPTY_MARK;
      back_q         <= EMPTY_MARK;
    end else begin
      valid_q <= accept;
      if (accept) begin
        data_out_q     <= data_out_d;
        pop_valid_q    <= stat_sel.popped;
        push_dropped_q <= stat_sel.dropped;
        count_a_q      <= COUNT_W'(fill_a_d);
        count_b_q      <= COUNT_W'(fill_b_d);
        front_q        <= front_d;
        back_q         <= back_d;
      end
    end
  end

  assign result_valid_o   = valid_q;
  assign data_out_o       = data_out_q;
  assign pop_valid_o      = pop_valid_q;
  assign push_dropped_o   = push_dropped_q;
  assign count_a_o        = count_a_q;
  assign count_b_o        = count_b_q;
  assign front_selected_o = front_q;
  assign back_selected_o  = back_q;

endmodule

// ===== hw/rtl/bdsq_cell.sv =====
// One byte slot of a shifting queue.
`timescale 1ns / 1ps
module bdsq_cell (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       shift_i,
  input  logic       load_i,
  input  logic [7:0] load_data_i,
  input  logic [7:0] nbr_i,
  output logic [7:0] data_d_o,
  output logic [7:0] data_q_o
);
  import bdsq_pkg::*;

  logic [7:0] data_q;
  logic [7:0] data_d;

  // Load wins over shift: overwrite-on-full shifts and writes the last slot
  always_comb begin
    data_d = data_q;
    if (load_i) begin
      data_d = load_data_i;
    end else if (shift_i) begin
      data_d = nbr_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= EMPTY_MARK;
    end else begin
      data_q <= data_d;
    end
  end

  assign data_d_o = data_d;
  assign data_q_o = data_q;

endmodule

// ===== hw/rtl/bdsq_lane.sv =====
// One queue: a row of cells plus fill count and tail register.
`timescale 1ns / 1ps
module bdsq_lane #(
  parameter int unsigned QUEUE_DEPTH = bdsq_pkg::QUEUE_DEPTH_DEF,
  localparam int unsigned FW = $clog2(QUEUE_DEPTH + 1),
  localparam int unsigned IW = $clog2(QUEUE_DEPTH)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bdsq_pkg::lane_cmd_e   cmd_i,
  input  logic [7:0]            data_i,
  output logic [FW-1:0]         fill_q_o,
  output logic [FW-1:0]         fill_d_o,
  output bdsq_pkg::lane_stat_t  stat_o
);
  import bdsq_pkg::*;

  logic [FW-1:0] fill_q, fill_d;
  logic [7:0]    tail_q, tail_d;
  logic          shift, load;
  logic [IW-1:0] load_idx;
  logic          full, empty;
  logic          popped, dropped;
  logic [7:0]    cell_q [QUEUE_DEPTH];
  logic [7:0]    cell_d [QUEUE_DEPTH];

  assign full  = (fill_q == FW'(QUEUE_DEPTH));
  assign empty = (fill_q == '0);

  // Command decode
  always_comb begin
    shift    = 1'b0;
    load     = 1'b0;
    load_idx = fill_q[IW-1:0];
    fill_d   = fill_q;
    tail_d   = tail_q;
    popped   = 1'b0;
    dropped  = 1'b0;
    unique case (cmd_i)
      LANE_PUSH: begin
        if (full) begin
          dropped = 1'b1;
        end else begin
          load   = 1'b1;
          fill_d = fill_q + FW'(1);
          tail_d = data_i;
        end
      end
      LANE_PUSH_OVR: begin
        if (full) begin
          // evict head, append at last slot
          shift    = 1'b1;
          load     = 1'b1;
          load_idx = IW'(QUEUE_DEPTH - 1);
          tail_d   = data_i;
        end else begin
          load   = 1'b1;
          fill_d = fill_q + FW'(1);
          tail_d = data_i;
        end
      end
      LANE_POP: begin
        if (!empty) begin
          shift  = 1'b1;
          popped = 1'b1;
          fill_d = fill_q - FW'(1);
          tail_d = (fill_q == FW'(1)) ? EMPTY_MARK : tail_q;
        end
      end
      default: begin
      end
    endcase
  end

  // Row of cells, each fed by its right neighbor, the last by the marker byte
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [7:0] nbr;
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign nbr = EMPTY_MARK;
    end else begin : g_mid
      assign nbr = cell_q[i+1];
    end
    bdsq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .shift_i     (shift),
      .load_i      (load && (load_idx == IW'(i))),
      .load_data_i (data_i),
      .nbr_i       (nbr),
      .data_d_o    (cell_d[i]),
      .data_q_o    (cell_q[i])
    );
  end

  // Fill count and tail byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      tail_q <= EMPTY_MARK;
    end else begin
      fill_q <= fill_d;
      tail_q <= tail_d;
    end
  end

  assign fill_q_o       = fill_q;
  assign fill_d_o       = fill_d;
  assign stat_o.head_q  = cell_q[0];
  assign stat_o.head_d  = cell_d[0];
  assign stat_o.tail_d  = tail_d;
  assign stat_o.popped  = popped;
  assign stat_o.dropped = dropped;

endmodule

// ===== hw/rtl/bdsq_checker.sv =====
// Port-level checker for the balanced dual shift queue, bound to the top.
`timescale 1ns / 1ps
`include "balanced_dual_shift_queue_macros.svh"
module bdsq_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic       result_valid_o,
  input logic [7:0] data_out_o,
  input logic       pop_valid_o,
  input logic       push_dropped_o,
  input logic [4:0] count_a_o,
  input logic [4:0] count_b_o
);
  import bdsq_pkg::*;

  // every accepted item gives a result on the next cycle
  `BDSQ_ASSERT_NEXT(a_result_follows, start_i && !busy_o, result_valid_o)

  // a pop never reports a dropped push
  `BDSQ_ASSERT_SAME(a_pop_not_drop, result_valid_o && pop_valid_o, !push_dropped_o)

  // nothing removed means the marker byte comes out
  `BDSQ_ASSERT_SAME(a_no_pop_mark, result_valid_o && !pop_valid_o, data_out_o == EMPTY_MARK)

  // a dropped push leaves both counts as the last result showed them
  `BDSQ_ASSERT_SAME(a_drop_keeps_counts, result_valid_o && push_dropped_o,
                    $stable(count_a_o) && $stable(count_b_o))

endmodule

bind balanced_dual_shift_queue bdsq_checker u_bdsq_checker (.*);

// ===== dv/tb_balanced_dual_shift_queue.sv =====
// Self-checking testbench for the balanced dual shift queue.
`timescale 1ns / 1ps
module tb_balanced_dual_shift_queue;
  import bdsq_pkg::*;

  localparam int unsigned DEPTH = QUEUE_DEPTH_DEF;

  // Opcodes outside the package enum; the block treats them as no-ops
  localparam logic [2:0] OP_RSVD_5 = 3'd5;
  localparam logic [2:0] OP_RSVD_6 = 3'd6;
  localparam logic [2:0] OP_RSVD_7 = 3'd7;

  // Queue indexes in the shadow state
  localparam int QA = 0;
  localparam int QB = 1;

  // Minimum number of random items per idling phase
  localparam int unsigned PHASE_ITEMS = 600;

  typedef struct {
    logic [2:0]  op;
    logic        sel;
    logic [7:0]  data;
    int unsigned phase;
    bit          drain_first;  // hold off until every result is back
  } queue_cmd_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic       pop_valid;
    logic       push_dropped;
    logic [4:0] count_a;
    logic [4:0] count_b;
    logic [7:0] front_sel;
    logic [7:0] back_sel;
  } queue_result_t;

  logic       clk_i          = 1'b0;
  logic       rst_ni         = 1'b0;
  logic       start_i        = 1'b0;
  logic [2:0] opcode_i       = OP_PUSH_DROP;
  logic       queue_select_i = 1'b0;
  logic [7:0] data_in_i      = 8'd0;
  logic       busy_o;
  logic       result_valid_o;
  logic [7:0] data_out_o;
  logic       pop_valid_o;
  logic       push_dropped_o;
  logic [4:0] count_a_o;
  logic [4:0] count_b_o;
  logic [7:0] front_selected_o;
  logic [7:0] back_selected_o;

  queue_cmd_t    queue_cmds_pending[$];
  queue_result_t predicted_results[$];
  bit            took_item = 1'b0;

  // Shadow copy of both queues
  logic [7:0]  shadow_slots [2][DEPTH];
  int unsigned shadow_fill [2];

  int unsigned fail_count      = 0;
  int unsigned items_taken     = 0;
  int unsigned results_checked = 0;
  int unsigned pops_done       = 0;
  int unsigned pushes_dropped  = 0;
  int unsigned evictions       = 0;

  balanced_dual_shift_queue #(
    .QUEUE_DEPTH(DEPTH)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .opcode_i        (opcode_i),
    .queue_select_i  (queue_select_i),
    .data_in_i       (data_in_i),
    .result_valid_o  (result_valid_o),
    .data_out_o      (data_out_o),
    .pop_valid_o     (pop_valid_o),
    .push_dropped_o  (push_dropped_o),
    .count_a_o       (count_a_o),
    .count_b_o       (count_b_o),
    .front_selected_o(front_selected_o),
    .back_selected_o (back_selected_o)
  );

  always #1 clk_i = ~clk_i;

  // Shift the whole queue one slot toward the head
  function automatic logic [7:0] pop_head(int q);
    logic [7:0] head;
    head = shadow_slots[q][0];
    for (int i = 0; i + 1 < DEPTH; i++) shadow_slots[q][i] = shadow_slots[q][i + 1];
    shadow_slots[q][DEPTH - 1] = EMPTY_MARK;
    shadow_fill[q]--;
    return head;
  endfunction

  function automatic void push_tail(int q, logic [7:0] byte_in);
    shadow_slots[q][shadow_fill[q]] = byte_in;
    shadow_fill[q]++;
  endfunction

  // Apply one item to the shadow queues and return what the block must answer
  function automatic queue_result_t predict_queue_step(logic [2:0] op, logic sel_in,
                                                       logic [7:0] din);
    queue_result_t r;
    int q;
    r.data_out     = EMPTY_MARK;
    r.pop_valid    = 1'b0;
    r.push_dropped = 1'b0;
    q = sel_in ? QB : QA;
    // balancing uses the counts from before the step
    if (op == OP_BAL_PUSH) q = (shadow_fill[QA] <= shadow_fill[QB]) ? QA : QB;
    else if (op == OP_BAL_POP) q = (shadow_fill[QA] >= shadow_fill[QB]) ? QA : QB;

    case (op)
      OP_PUSH_DROP, OP_BAL_PUSH: begin
        if (shadow_fill[q] >= DEPTH) begin
          r.push_dropped = 1'b1;
          pushes_dropped++;
        end else begin
          push_tail(q, din);
        end
      end
      OP_PUSH_OVR: begin
        if (shadow_fill[q] >= DEPTH) begin
          void'(pop_head(q));
          evictions++;
        end
        push_tail(q, din);
      end
      OP_POP, OP_BAL_POP: begin
        if (shadow_fill[q] != 0) begin
          r.data_out  = pop_head(q);
          r.pop_valid = 1'b1;
          pops_done++;
        end
      end
      default: ;
    endcase

    r.count_a = shadow_fill[QA][4:0];
    r.count_b = shadow_fill[QB][4:0];
    if (shadow_fill[q] == 0) begin
      r.front_sel = EMPTY_MARK;
      r.back_sel  = EMPTY_MARK;
    end else begin
      r.front_sel = shadow_slots[q][0];
      r.back_sel  = shadow_slots[q][shadow_fill[q] - 1];
    end
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  task automatic add_cmd(logic [2:0] op, logic sel, logic [7:0] data, int unsigned phase,
                         bit drain_first);
    queue_cmd_t c;
    c.op          = op;
    c.sel         = sel;
    c.data        = data;
    c.phase       = phase;
    c.drain_first = drain_first;
    queue_cmds_pending.push_back(c);
  endtask

  // Driver: present the oldest pending item, idling at the phase's rate
  always @(negedge clk_i) begin
    queue_cmd_t  nxt;
    bit          drive_now;
    int unsigned idle_pct;
    drive_now = 1'b0;
    if (took_item) void'(queue_cmds_pending.pop_front());
    if (rst_ni && queue_cmds_pending.size() != 0) begin
      nxt = queue_cmds_pending[0];
      idle_pct = (nxt.phase == 0) ? 38 : (nxt.phase == 1) ? 50 : 0;
      if (nxt.drain_first && predicted_results.size() != 0) drive_now = 1'b0;
      else drive_now = ($urandom_range(99) >= idle_pct);
    end
    start_i <= drive_now;
    if (drive_now) begin
      opcode_i       <= nxt.op;
      queue_select_i <= nxt.sel;
      data_in_i      <= nxt.data;
    end
  end

  // Monitor: predict on acceptance, compare each result with the oldest prediction
  always @(posedge clk_i) begin
    queue_result_t exp_r;
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        predicted_results.push_back(predict_queue_step(opcode_i, queue_select_i, data_in_i));
        items_taken++;
      end
      if (result_valid_o === 1'b1) begin
        if (predicted_results.size() == 0) begin
          $error("result with no item outstanding");
          fail_count++;
        end else begin
          exp_r = predicted_results.pop_front();
          check_field("data_out", 32'(exp_r.data_out), 32'(data_out_o));
          check_field("pop_valid", 32'(exp_r.pop_valid), 32'(pop_valid_o));
          check_field("push_dropped", 32'(exp_r.push_dropped), 32'(push_dropped_o));
          check_field("count_a", 32'(exp_r.count_a), 32'(count_a_o));
          check_field("count_b", 32'(exp_r.count_b), 32'(count_b_o));
          check_field("front_selected", 32'(exp_r.front_sel), 32'(front_selected_o));
          check_field("back_selected", 32'(exp_r.back_sel), 32'(back_selected_o));
          results_checked++;
        end
      end
    end
    took_item <= rst_ni && start_i && !busy_o;
  end

  // Stimulus, reset and end of run
  initial begin
    int unsigned kind;
    int unsigned len;
    int unsigned made;
    logic        sel;
    logic [2:0]  op;

    for (int q = 0; q < 2; q++) begin
      for (int i = 0; i < DEPTH; i++) shadow_slots[q][i] = EMPTY_MARK;
      shadow_fill[q] = 0;
    end

    // Directed: empty pops, unused opcodes, tie-breaks, single-entry pops
    add_cmd(OP_POP, 1'b0, 8'hFF, 0, 1'b0);
    add_cmd(OP_POP, 1'b1, 8'h00, 0, 1'b0);
    add_cmd(OP_BAL_POP, 1'b0, 8'h5A, 0, 1'b0);
    add_cmd(OP_RSVD_5, 1'b1, 8'hAA, 0, 1'b0);
    add_cmd(OP_RSVD_6, 1'b0, 8'h55, 0, 1'b0);
    add_cmd(OP_RSVD_7, 1'b1, 8'hFF, 0, 1'b0);
    add_cmd(OP_PUSH_DROP, 1'b0, 8'h00, 0, 1'b0);
    add_cmd(OP_PUSH_OVR, 1'b1, 8'hFF, 0, 1'b0);
    add_cmd(OP_BAL_PUSH, 1'b0, 8'h80, 0, 1'b0);  // tie goes to A
    add_cmd(OP_BAL_PUSH, 1'b0, 8'h7F, 0, 1'b0);  // B is shorter
    add_cmd(OP_BAL_PUSH, 1'b1, 8'h01, 0, 1'b0);
    add_cmd(OP_BAL_POP, 1'b1, 8'h00, 0, 1'b0);   // A is longer
    add_cmd(OP_BAL_POP, 1'b1, 8'h00, 0, 1'b0);   // tie goes to A
    add_cmd(OP_BAL_POP, 1'b0, 8'h00, 0, 1'b0);   // B is longer
    add_cmd(OP_POP, 1'b1, 8'h33, 0, 1'b0);       // single entry left in B
    add_cmd(OP_POP, 1'b0, 8'hCC, 0, 1'b0);       // single entry left in A
    add_cmd(OP_POP, 1'b0, 8'h00, 0, 1'b0);

    // Random episodes: fill to full, drain to empty, balanced runs, noise
    for (int unsigned ph = 0; ph < 3; ph++) begin
      made = 0;
      while (made < PHASE_ITEMS) begin
        kind = $urandom_range(9);
        sel  = 1'($urandom_range(1));
        case (kind)
          0, 1, 2: len = $urandom_range(36, 14);
          3, 4:    len = $urandom_range(34, 10);
          5, 6:    len = $urandom_range(40, 20);
          7:       len = $urandom_range(40, 10);
          default: len = $urandom_range(20, 5);
        endcase
        for (int unsigned k = 0; k < len; k++) begin
          case (kind)
            0, 1, 2: op = $urandom_range(1) ? OP_PUSH_OVR : OP_PUSH_DROP;
            3, 4:    op = $urandom_range(3) == 0 ? OP_BAL_POP : OP_POP;
            5, 6:    op = OP_BAL_PUSH;
            7:       op = OP_BAL_POP;
            default: op = ($urandom_range(39) == 0) ? 3'($urandom_range(7, 5))
                                                    : 3'($urandom_range(4));
          endcase
          // first item of every phase waits for the block to drain
          add_cmd(op, (kind >= 8) ? 1'($urandom_range(1)) : sel, 8'($urandom_range(255)),
                  ph, made == 0 && k == 0);
        end
        made += len;
      end
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (queue_cmds_pending.size() != 0 || predicted_results.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (predicted_results.size() != 0) begin
      $error("%0d predicted results never arrived", predicted_results.size());
      fail_count++;
    end

    $display("Covered %0d items and %0d results across three idling phases.",
             items_taken, results_checked);
    $display("Saw %0d pops, %0d dropped pushes and %0d full-queue evictions.",
             pops_done, pushes_dropped, evictions);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #200_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/bdsq_pkg.sv
hw/rtl/bdsq_cell.sv
hw/rtl/bdsq_lane.sv
hw/rtl/balanced_dual_shift_queue.sv
hw/rtl/bdsq_checker.sv
dv/tb_balanced_dual_shift_queue.sv
